>>> rtl/psuid_pkg.sv
// ----------------------------------------------------------------------------
// psuid_pkg: shared types and constants
// Scope counts, field widths and the sequencer states of the statistics block.
// ----------------------------------------------------------------------------
package psuid_pkg;

	localparam int NUM_RANGES   = 4;
	localparam int SCOPES       = NUM_RANGES + 1;
	localparam int SET_CAPACITY = 4096;
	localparam int SCOPE_W      = 3;
	localparam int IDX_W        = $clog2(SET_CAPACITY);
	localparam int CNT_W        = IDX_W + 1;
	localparam int MEM_DEPTH    = SCOPES * SET_CAPACITY;
	localparam int ADDR_W       = $clog2(MEM_DEPTH);

	localparam logic [15:0] SPEED_LIMIT = 16'd15000;
	localparam logic [19:0] ALT_LIMIT   = 20'd100000;
	localparam logic [19:0] MIN_NONE    = 20'd999999;
	localparam logic [19:0] MIN_MARK    = 20'd900000;

	localparam logic [1:0] CMD_SIGHT = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;

	localparam logic [2:0] REG_RANGE_ONE   = 3'd0;
	localparam logic [2:0] REG_RANGE_TWO   = 3'd1;
	localparam logic [2:0] REG_RANGE_THREE = 3'd2;
	localparam logic [2:0] REG_RANGE_FOUR  = 3'd3;
	localparam logic [2:0] REG_DEFAULT     = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCOPE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] unique_count;
		logic [31:0]      total_sightings;
		logic [15:0]      max_distance;
		logic [13:0]      max_speed;
		logic [16:0]      max_altitude;
		logic [16:0]      min_altitude;
		logic             speed_record;
	} result_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  scope_select;
		logic [23:0] icao;
		logic        distance_valid;
		logic [15:0] distance;
		logic [15:0] speed;
		logic [17:0] altitude;
		logic        on_ground;
	} sight_t;

endpackage

>>> rtl/psuid_if.sv
// ----------------------------------------------------------------------------
// psuid_if: valid/ready channel
// Carries one word per handshake.
// ----------------------------------------------------------------------------
interface psuid_in_if import psuid_pkg::*; (input logic clk);
	logic   valid;
	logic   ready;
	sight_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface psuid_out_if import psuid_pkg::*; (input logic clk);
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/per_scope_unique_id_stats.sv
// ----------------------------------------------------------------------------
// per_scope_unique_id_stats: per-scope aircraft sighting statistics
// Five scopes of counters and extremes plus a sorted unique-ID set per scope
// held in one synchronous memory.
// ----------------------------------------------------------------------------
// channel   dir  protocol      word
// in_ch     in   valid/ready   command, scope, sighting fields
// out_ch    out  valid/ready   figures of the reported scope
// cfg       in   write only    range limits, default scope
//
// A read or reset goes from accept through the scope state to the result
// register. A sighting visits each scope in turn: a check of the scope, a
// binary search of read/compare pairs (up to 13 steps), a shift of one
// read/write pair per moved entry plus one more pair, and a store. One word
// in flight; the result register lets the next word be accepted while the
// result waits.
// Reset clears all figures; set contents are never read past the count, so no
// memory clear is needed.
// ----------------------------------------------------------------------------
module per_scope_unique_id_stats import psuid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	psuid_in_if.sink           in_ch,
	psuid_out_if.source        out_ch,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// configuration
	logic [15:0] range_q [NUM_RANGES];
	logic [2:0]  dflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q[0] <= 16'd500;
			range_q[1] <= 16'd1000;
			range_q[2] <= 16'd2500;
			range_q[3] <= 16'd5000;
			dflt_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_ONE:   range_q[0] <= cfg_data;
				REG_RANGE_TWO:   range_q[1] <= cfg_data;
				REG_RANGE_THREE: range_q[2] <= cfg_data;
				REG_RANGE_FOUR:  range_q[3] <= cfg_data;
				REG_DEFAULT:     dflt_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// per-scope figures in flops (five entries each)
	logic [CNT_W-1:0] ucnt_q [SCOPES];
	logic [31:0]      tot_q  [SCOPES];
	logic [15:0]      mdist_q[SCOPES];
	logic [13:0]      mspd_q [SCOPES];
	logic [16:0]      malt_q [SCOPES];
	logic [19:0]      nalt_q [SCOPES];

	// ID store
	logic [23:0]       mem [MEM_DEPTH];
	logic [23:0]       rd_data;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              mem_we;
	logic [23:0]       wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	state_t state_q, state_d;
	sight_t w_q;
	logic [SCOPE_W-1:0] scope_q, rep_q;
	logic [CNT_W-1:0]   lo_q, hi_q, pos_q;
	logic               rec_q;
	logic               out_valid_q;
	result_t            out_q;

	function automatic logic [ADDR_W-1:0] addr_of(logic [SCOPE_W-1:0] s,
		logic [CNT_W-1:0] i);
		return ADDR_W'(s) * ADDR_W'(SET_CAPACITY) + ADDR_W'(i[IDX_W-1:0]);
	endfunction

	logic [CNT_W-1:0] mid;
	logic             scope_in;
	logic [19:0]      alt_ext;
	logic             alt_ok;
	logic             last_scope;
	logic             dup_hit;
	logic             skip_ins;

	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign last_scope = (scope_q == SCOPE_W'(NUM_RANGES));
	assign alt_ext    = {{2{w_q.altitude[17]}}, w_q.altitude};
	assign alt_ok     = !w_q.on_ground && !alt_ext[19] && (alt_ext != '0)
		&& (alt_ext < ALT_LIMIT);

	// search result: duplicate found or set full, nothing to insert
	assign dup_hit  = (rd_data == w_q.icao);
	assign skip_ins = (lo_q < ucnt_q[scope_q] && dup_hit)
		|| ucnt_q[scope_q] == CNT_W'(SET_CAPACITY);

	always_comb begin
		if (scope_q == '0) scope_in = 1'b1;
		else scope_in = w_q.distance_valid
			&& (w_q.distance <= range_q[2'(scope_q - SCOPE_W'(1))]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_SCOPE;
			ST_SCOPE: begin
				if (w_q.command != CMD_SIGHT) state_d = ST_OUT;
				else if (!scope_in) state_d = last_scope ? ST_OUT : ST_SCOPE;
				else if (w_q.icao == '0 || ucnt_q[scope_q] == '0)
					state_d = ST_PUT;
				else state_d = ST_SRCH_RD;
			end
			ST_SRCH_RD:  state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				if (lo_q < hi_q) state_d = ST_SRCH_RD;
				else if (skip_ins) state_d = ST_PUT;
				else state_d = ST_SHIFT_RD;
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = (pos_q == lo_q) ? ST_PUT : ST_SHIFT_RD;
			ST_PUT:      state_d = last_scope ? ST_OUT : ST_SCOPE;
			ST_OUT:      if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		rd_addr = addr_of(scope_q, mid);
		wr_addr = addr_of(scope_q, pos_q);
		wr_data = rd_data;
		mem_we  = 1'b0;
		unique case (state_q)
			ST_SHIFT_RD: rd_addr = addr_of(scope_q, pos_q - CNT_W'(1));
			ST_SHIFT_WR: mem_we = 1'b1;
			ST_PUT: begin
				wr_addr = addr_of(scope_q, lo_q);
				wr_data = w_q.icao;
				mem_we  = (w_q.icao != '0) && !(lo_q == '1);
			end
			default: ;
		endcase
	end

	// lo_q all ones marks "duplicate or full, skip"

	logic [19:0] min_rd;
	assign min_rd = nalt_q[rep_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int s = 0; s < SCOPES; s++) begin
				ucnt_q[s] <= '0; tot_q[s] <= '0; mdist_q[s] <= '0;
				mspd_q[s] <= '0; malt_q[s] <= '0; nalt_q[s] <= MIN_NONE;
			end
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					w_q     <= in_ch.data;
					scope_q <= '0;
					rec_q   <= 1'b0;
					if (in_ch.data.scope_select <= SCOPE_W'(NUM_RANGES))
						rep_q <= in_ch.data.scope_select;
					else if (dflt_q <= SCOPE_W'(NUM_RANGES)) rep_q <= dflt_q;
					else rep_q <= '0;
					if (in_ch.data.command == CMD_RESET)
						for (int s = 0; s < SCOPES; s++)
							if (in_ch.data.scope_select > SCOPE_W'(NUM_RANGES)
								|| in_ch.data.scope_select == SCOPE_W'(s)) begin
								ucnt_q[s] <= '0; tot_q[s] <= '0; mdist_q[s] <= '0;
								mspd_q[s] <= '0; malt_q[s] <= '0;
								nalt_q[s] <= MIN_NONE;
							end
				end
				ST_SCOPE: if (w_q.command == CMD_SIGHT) begin
					if (scope_in) begin
						tot_q[scope_q] <= tot_q[scope_q] + 32'd1;
						if (w_q.distance_valid && w_q.distance > mdist_q[scope_q])
							mdist_q[scope_q] <= w_q.distance;
						if (w_q.speed > {2'b0, mspd_q[scope_q]}
							&& w_q.speed < SPEED_LIMIT) begin
							mspd_q[scope_q] <= w_q.speed[13:0];
							if (scope_q == rep_q) rec_q <= 1'b1;
						end
						if (alt_ok) begin
							if (alt_ext[16:0] > malt_q[scope_q])
								malt_q[scope_q] <= alt_ext[16:0];
							if (alt_ext < nalt_q[scope_q])
								nalt_q[scope_q] <= alt_ext;
						end
						lo_q <= '0;
						hi_q <= ucnt_q[scope_q];
						if (ucnt_q[scope_q] == CNT_W'(SET_CAPACITY) && w_q.icao != '0)
							lo_q <= '1;
					end else if (!last_scope) scope_q <= scope_q + SCOPE_W'(1);
				end
				ST_SRCH_CMP: begin
					if (lo_q < hi_q) begin
						if (rd_data < w_q.icao) lo_q <= mid + CNT_W'(1);
						else hi_q <= mid;
					end else begin
						pos_q <= ucnt_q[scope_q];
						if (skip_ins) begin
							lo_q  <= '1;
							pos_q <= '1;
						end
					end
				end
				ST_SHIFT_WR: if (pos_q != lo_q) pos_q <= pos_q - CNT_W'(1);
				ST_PUT: begin
					if (w_q.icao != '0 && !(lo_q == '1))
						ucnt_q[scope_q] <= ucnt_q[scope_q] + CNT_W'(1);
					if (!last_scope) scope_q <= scope_q + SCOPE_W'(1);
				end
				ST_OUT: if (!out_valid_q || out_ch.ready) begin
					out_valid_q           <= 1'b1;
					out_q.unique_count    <= ucnt_q[rep_q];
					out_q.total_sightings <= tot_q[rep_q];
					out_q.max_distance    <= mdist_q[rep_q];
					out_q.max_speed       <= mspd_q[rep_q];
					out_q.max_altitude    <= malt_q[rep_q];
					out_q.min_altitude    <= (min_rd >= MIN_MARK) ? '0 : min_rd[16:0];
					out_q.speed_record    <= rec_q;
				end
				default: ;
			endcase
		end
	end

	// skip shift when search was aborted: go straight to PUT which also skips
	// (handled by lo_q all ones)

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

>>> test/psuid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psuid_checker: scoreboard for the sighting statistics block
// Watches the input, output and register write ports, keeps its own copy of
// every scope's figures and compares each result word with the prediction.
// ----------------------------------------------------------------------------
module psuid_checker import psuid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	psuid_in_if         in_ch,
	psuid_out_if        out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending
);

	logic [15:0] range_lim [NUM_RANGES];
	logic [2:0]  dflt_scope;

	bit          id_set [SCOPES][int unsigned];
	int          id_cnt [SCOPES];
	logic [31:0] totals [SCOPES];
	logic [15:0] far_dist [SCOPES];
	logic [13:0] top_speed [SCOPES];
	int          high_alt [SCOPES];
	int          low_alt [SCOPES];

	result_t     figures_q [$];

	function automatic void wipe_scope(int s);
		id_set[s].delete();
		id_cnt[s]    = 0;
		totals[s]    = '0;
		far_dist[s]  = '0;
		top_speed[s] = '0;
		high_alt[s]  = 0;
		low_alt[s]   = int'(MIN_NONE);
	endfunction

	function automatic result_t figures_for(sight_t w);
		int      rep;
		int      alt;
		bit      rec;
		result_t r;
		rep = (w.scope_select <= NUM_RANGES) ? int'(w.scope_select) :
			(dflt_scope <= NUM_RANGES) ? int'(dflt_scope) : 0;
		alt = int'($signed(w.altitude));
		rec = 0;
		if (w.command == CMD_SIGHT) begin
			for (int s = 0; s < SCOPES; s++) begin
				if (s > 0 && (!w.distance_valid || w.distance > range_lim[s-1]))
					continue;
				totals[s]++;
				if (w.icao != 0 && !id_set[s].exists(w.icao) && id_cnt[s] < SET_CAPACITY) begin
					id_set[s][w.icao] = 1;
					id_cnt[s]++;
				end
				if (w.distance_valid && w.distance > far_dist[s])
					far_dist[s] = w.distance;
				if (w.speed > top_speed[s] && w.speed < SPEED_LIMIT) begin
					top_speed[s] = w.speed[13:0];
					if (s == rep)
						rec = 1;
				end
				if (!w.on_ground && alt > 0 && alt < int'(ALT_LIMIT)) begin
					if (alt > high_alt[s])
						high_alt[s] = alt;
					if (alt < low_alt[s])
						low_alt[s] = alt;
				end
			end
		end else if (w.command == CMD_RESET) begin
			if (w.scope_select <= NUM_RANGES)
				wipe_scope(w.scope_select);
			else
				for (int s = 0; s < SCOPES; s++)
					wipe_scope(s);
		end
		r.unique_count    = CNT_W'(id_cnt[rep]);
		r.total_sightings = totals[rep];
		r.max_distance    = far_dist[rep];
		r.max_speed       = top_speed[rep];
		r.max_altitude    = 17'(high_alt[rep]);
		// sentinel reads back as zero
		r.min_altitude    = (low_alt[rep] >= int'(MIN_MARK)) ? '0 : 17'(low_alt[rep]);
		r.speed_record    = rec;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lim[0] <= 16'd500;
			range_lim[1] <= 16'd1000;
			range_lim[2] <= 16'd2500;
			range_lim[3] <= 16'd5000;
			dflt_scope   <= '0;
			for (int s = 0; s < SCOPES; s++)
				wipe_scope(s);
			figures_q.delete();
			fails <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DEFAULT)
					dflt_scope <= cfg_data[2:0];
				else if (cfg_index < REG_DEFAULT)
					range_lim[cfg_index[1:0]] <= cfg_data;
			end
			if (in_ch.valid && in_ch.ready)
				figures_q.push_back(figures_for(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				if (figures_q.size() == 0) begin
					$display("%0t: result word with nothing expected: %p", $time,
						out_ch.data);
					fails <= fails + 1;
				end else if (out_ch.data !== figures_q[0]) begin
					$display("%0t: mismatch expected %p", $time, figures_q[0]);
					$display("%0t:          actual   %p", $time, out_ch.data);
					fails <= fails + 1;
					void'(figures_q.pop_front());
				end else begin
					void'(figures_q.pop_front());
				end
			end
		end
	end

	// a word accepted this cycle is already queued when pending is read
	assign pending = figures_q.size();

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for per_scope_unique_id_stats
// Directed corner words, then phases of random sightings, reads and resets
// under several range settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import psuid_pkg::*;

	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fails;
	int          pending;

	int          n_words;
	int          n_sight;
	int          n_ctl;
	logic [23:0] id_pool [24];

	psuid_in_if  in_ch (clk);
	psuid_out_if out_ch (clk);

	per_scope_unique_id_stats u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	psuid_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// mostly no gap, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// result side back-pressure: hold ready at one level for a random run
	int hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt     <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ch.ready <= 1'b0;
			hold_cnt     <= gap_len();
		end else begin
			out_ch.ready <= 1'b1;
			hold_cnt     <= $urandom_range(0, 40);
		end
	end

	task automatic send_word(sight_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		do @(posedge clk); while (!in_ch.ready);
		n_words++;
		if (w.command == CMD_SIGHT)
			n_sight++;
		else
			n_ctl++;
	endtask

	task automatic send_fields(logic [1:0] cmd, logic [2:0] sel, logic [23:0] id,
			logic dv, logic [15:0] dst, logic [15:0] spd, int alt, logic gnd);
		sight_t w;
		w.command        = cmd;
		w.scope_select   = sel;
		w.icao           = id;
		w.distance_valid = dv;
		w.distance       = dst;
		w.speed          = spd;
		w.altitude       = alt[17:0];
		w.on_ground      = gnd;
		send_word(w);
	endtask

	// sender stops until every result is back, then the block is idle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ranges(logic [15:0] r1, logic [15:0] r2, logic [15:0] r3,
			logic [15:0] r4, logic [2:0] dflt);
		logic [15:0] vals [5];
		vals = '{r1, r2, r3, r4, {13'd0, dflt}};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random word: mostly sightings from a small ID pool so repeats happen
	task automatic send_random();
		sight_t w;
		int     r;
		r = $urandom_range(0, 99);
		w.command = (r < 75) ? CMD_SIGHT : (r < 91) ? CMD_READ :
			(r < 96) ? CMD_SPARE : CMD_RESET;
		w.scope_select   = $urandom_range(0, 7);
		r = $urandom_range(0, 19);
		w.icao           = (r == 0) ? 24'd0 : (r == 1) ? 24'($urandom) :
			id_pool[$urandom_range(0, 23)];
		w.distance_valid = ($urandom_range(0, 7) != 0);
		r = $urandom_range(0, 9);
		w.distance       = (r < 7) ? 16'($urandom_range(0, 6000)) : 16'($urandom);
		r = $urandom_range(0, 9);
		w.speed          = (r < 7) ? 16'($urandom_range(0, 15100)) : 16'($urandom);
		r = $urandom_range(0, 9);
		w.altitude       = (r < 7) ? 18'($urandom_range(1, 99999)) : 18'($urandom);
		w.on_ground      = ($urandom_range(0, 7) == 0);
		send_word(w);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		n_words     = 0;
		n_sight     = 0;
		n_ctl       = 0;
		for (int i = 0; i < 24; i++)
			id_pool[i] = 24'($urandom);
		id_pool[0] = 24'd1;
		id_pool[1] = 24'hFFFFFF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset-value ranges, field extremes, every command
		send_fields(CMD_READ,  3'd0, 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		send_fields(CMD_SIGHT, 3'd0, 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		send_fields(CMD_SIGHT, 3'd1, 24'hFFFFFF, 1'b1, 16'd0, 16'd14999, 1, 1'b0);
		send_fields(CMD_SIGHT, 3'd1, 24'd1, 1'b1, 16'd500, 16'd15000, 99999, 1'b0);
		send_fields(CMD_SIGHT, 3'd2, 24'd1, 1'b1, 16'd501, 16'd65535, 100000, 1'b0);
		send_fields(CMD_SIGHT, 3'd4, 24'h5A5A5A, 1'b1, 16'd65535, 16'd100, -1, 1'b0);
		send_fields(CMD_SIGHT, 3'd0, 24'h000123, 1'b0, 16'd10, 16'd200, -131072, 1'b0);
		send_fields(CMD_SIGHT, 3'd3, 24'h000124, 1'b1, 16'd2500, 16'd300, 131071, 1'b0);
		send_fields(CMD_SIGHT, 3'd3, 24'h000125, 1'b1, 16'd1000, 16'd14998, 5000, 1'b1);
		send_fields(CMD_SIGHT, 3'd5, 24'h000126, 1'b1, 16'd5000, 16'd1, 250, 1'b0);
		send_fields(CMD_SIGHT, 3'd7, 24'h000127, 1'b1, 16'd5001, 16'd2, 0, 1'b0);
		for (int s = 0; s < 8; s++)
			send_fields(CMD_READ, s[2:0], 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		send_fields(CMD_SPARE, 3'd2, 24'hABCDEF, 1'b1, 16'd1, 16'd1, 10, 1'b0);
		send_fields(CMD_RESET, 3'd1, 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		send_fields(CMD_READ,  3'd1, 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		send_fields(CMD_RESET, 3'd7, 24'd0, 1'b0, 16'd0, 16'd0, 0, 1'b0);
		drain();

		// phase settings: two fixed sets with extreme values, then random
		write_ranges(16'd0, 16'd65535, 16'd3000, 16'd100, 3'd7);
		repeat (30) send_random();
		drain();
		write_ranges(16'd65535, 16'd1200, 16'd0, 16'd4000, 3'd4);
		repeat (30) send_random();
		drain();
		write_ranges(16'($urandom_range(0, 6000)), 16'($urandom_range(0, 6000)),
			16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
		repeat (40) send_random();
		drain();

		repeat (50) @(posedge clk);
		$display("Sent %0d words: %0d sightings and %0d reads, resets or spare commands,",
			n_words, n_sight, n_ctl);
		$display("under 4 range settings with stalls on both channels.");
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", pending);
		$display("Verification failed");
		$finish;
	end

endmodule
